// ----- hw/rtl/fblm_pkg.sv -----
package fblm_pkg;

   localparam int PAGES      = 64;
   localparam int PAGE_W     = 6;
   localparam int BLOCKS     = 8;
   localparam int BLK_W      = 3;
   localparam int ADDR_W     = 9;
   localparam int STORE_LAST = 511;
   localparam int STORE_DEPTH = 512;
   localparam int SECT_W     = 24;
   localparam int DB_W       = 18;
   localparam int CNT_W      = 32;
   localparam int VIC_W      = 17;
   localparam int FVN_W      = 16;
   localparam int SEEN_CNT_W = 7;
   localparam int ENTRY_W    = 26;
   localparam int REQ_W      = 56;
   localparam int RSP_W      = 152;

   localparam logic [1:0] PG_FREE    = 2'd0;
   localparam logic [1:0] PG_INVALID = 2'd1;
   localparam logic [1:0] PG_VALID   = 2'd2;

   typedef enum logic [3:0] {
      ACT_ERASE, ACT_READ, ACT_WRITE, ACT_APPEND_BLK, ACT_APPEND_ANY,
      ACT_BLK_STATUS, ACT_STORE_STATUS, ACT_FIND_DATA, ACT_FIND_FREE,
      ACT_SEQ_TEST, ACT_SWITCH_MERGE, ACT_MERGE, ACT_FULL_MERGE, ACT_ADV_VICTIM
   } act_type;

   typedef enum logic [2:0] {
      MODE_PAGE, MODE_SCAN, MODE_FM_PAGE, MODE_FM_OUT, MODE_INVAL
   } mode_type;

   typedef struct packed {
      logic              load;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      mode_type          mode;
      logic              wr_free;
      logic              seen_rd;
      logic [PAGE_W-1:0] seen_addr;
      logic              seen_add;
      logic              fin;
      logic              result;
   } cmd_type;

   typedef struct packed {
      logic [3:0]            act;
      logic [BLK_W-1:0]      blk;
      logic [PAGE_W-1:0]     off;
      logic                  page_valid;
      logic [SEEN_CNT_W-1:0] seen_cnt;
      logic                  rsp_busy;
      logic                  ev_write;
      logic                  ev_valid;
   } stat_type;

endpackage

// ----- hw/rtl/fblm_dpath.sv -----
module fblm_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  fblm_pkg::cmd_type                cmd,
   output fblm_pkg::stat_type               stat,
   input  logic [fblm_pkg::REQ_W-1:0]       req_tdata,
   input  logic                             csr_wr_en,
   input  logic [fblm_pkg::FVN_W-1:0]       csr_wr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fblm_pkg::RSP_W-1:0]       rsp_tdata
);

   logic [fblm_pkg::ENTRY_W-1:0] mem [0:fblm_pkg::STORE_DEPTH-1];
   logic [fblm_pkg::DB_W-1:0]    seen_mem [0:fblm_pkg::PAGES-1];

   logic [3:0]                   act_ff;
   logic [fblm_pkg::BLK_W-1:0]   blk_ff;
   logic [fblm_pkg::PAGE_W-1:0]  off_ff;
   logic [fblm_pkg::SECT_W-1:0]  pv_ff;
   logic [fblm_pkg::DB_W-1:0]    db_ff;

   logic                         ev_valid_ff;
   fblm_pkg::mode_type           ev_mode_ff;
   logic [fblm_pkg::ADDR_W-1:0]  ev_addr_ff;
   logic [fblm_pkg::ENTRY_W-1:0] mem_q_ff;
   logic                         seen_v_ff;
   logic [fblm_pkg::DB_W-1:0]    seen_q_ff;

   logic                         ok_ff, found_ff, free_ff, full_ff, fv_ff;
   logic                         blk_fv_ff, blk_free_ff, dup_ff;
   logic [fblm_pkg::BLK_W-1:0]   fb_ff;
   logic [1:0]                   ps_ff;
   logic [fblm_pkg::SECT_W-1:0]  pd_ff, v_ff;
   logic [fblm_pkg::DB_W-1:0]    base_ff, d_ff;
   logic [fblm_pkg::SEEN_CNT_W-1:0] seen_cnt_ff;

   logic [fblm_pkg::CNT_W-1:0]   erase_ff, switch_ff, fmerge_ff;
   logic [fblm_pkg::VIC_W-1:0]   victim_ff;
   logic [fblm_pkg::FVN_W-1:0]   first_ff;
   logic                         rsp_valid_ff;
   logic [fblm_pkg::RSP_W-1:0]   rsp_data_ff;

   logic [1:0]                   ev_st;
   logic [fblm_pkg::SECT_W-1:0]  ev_sec;
   logic [fblm_pkg::PAGE_W-1:0]  ev_pg;
   logic                         pg_first, pg_last;
   logic                         cur_fv, cur_blk_free;
   logic                         ev_we, mem_we;
   logic [fblm_pkg::ENTRY_W-1:0] ev_wd, mem_wd;
   logic [fblm_pkg::ADDR_W-1:0]  mem_wa;
   logic [fblm_pkg::SEEN_CNT_W:0] erase_inc, fm_inc;
   logic                         sw_inc, adv;
   logic [fblm_pkg::VIC_W-1:0]   victim_nxt, victim_last;
   logic                         status_act;

   function automatic logic [fblm_pkg::CNT_W-1:0] sat_add(
      input logic [fblm_pkg::CNT_W-1:0] a,
      input logic [fblm_pkg::SEEN_CNT_W:0] n);
      logic [fblm_pkg::CNT_W:0] s;
      s = {1'b0, a} + {{(fblm_pkg::CNT_W-fblm_pkg::SEEN_CNT_W){1'b0}}, n};
      return s[fblm_pkg::CNT_W] ? '1 : s[fblm_pkg::CNT_W-1:0];
   endfunction

   assign ev_st        = mem_q_ff[fblm_pkg::ENTRY_W-1 -: 2];
   assign ev_sec       = mem_q_ff[fblm_pkg::SECT_W-1:0];
   assign ev_pg        = ev_addr_ff[fblm_pkg::PAGE_W-1:0];
   assign pg_first     = (ev_pg == '0);
   assign pg_last      = (ev_pg == '1);
   assign cur_fv       = pg_first ? 1'b0 : blk_fv_ff;
   assign cur_blk_free = (pg_first ? 1'b1 : blk_free_ff) & (ev_st == fblm_pkg::PG_FREE);

   // write port of the evaluate stage
   always_comb begin
      ev_we = 1'b0;
      ev_wd = {fblm_pkg::PG_VALID, pv_ff};
      if (ev_valid_ff) begin
         unique case (ev_mode_ff)
            fblm_pkg::MODE_PAGE:
               ev_we = (act_ff == fblm_pkg::ACT_WRITE) && (ev_st == fblm_pkg::PG_FREE);
            fblm_pkg::MODE_SCAN:
               ev_we = ((act_ff == fblm_pkg::ACT_APPEND_BLK) ||
                        (act_ff == fblm_pkg::ACT_APPEND_ANY)) &&
                       (ev_st == fblm_pkg::PG_FREE) && !ok_ff;
            fblm_pkg::MODE_INVAL: begin
               ev_we = (ev_st == fblm_pkg::PG_VALID) && (ev_sec == v_ff);
               ev_wd = {fblm_pkg::PG_INVALID, {fblm_pkg::SECT_W{1'b0}}};
            end
            default: ev_we = 1'b0;
         endcase
      end
   end

   assign mem_we = ev_we | cmd.wr_free;
   assign mem_wa = cmd.wr_free ? cmd.addr : ev_addr_ff;
   assign mem_wd = cmd.wr_free ? '0 : ev_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seen_add && !dup_ff) begin
         seen_mem[seen_cnt_ff[fblm_pkg::PAGE_W-1:0]] <= d_ff;
      end
      if (cmd.seen_rd) begin
         seen_q_ff <= seen_mem[cmd.seen_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff  <= 1'b0;
         seen_v_ff    <= 1'b0;
         seen_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff <= cmd.rd_en;
         seen_v_ff   <= cmd.seen_rd;
         if (cmd.load) begin
            seen_cnt_ff <= '0;
         end else if (cmd.seen_add && !dup_ff) begin
            seen_cnt_ff <= seen_cnt_ff + 1'b1;
         end
         if (cmd.result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request fields, pipeline tags and per-action accumulators
   always_ff @(posedge clock) begin
      ev_mode_ff <= cmd.mode;
      ev_addr_ff <= cmd.addr;
      if (cmd.load) begin
         act_ff   <= req_tdata[3:0];
         blk_ff   <= req_tdata[6:4];
         off_ff   <= req_tdata[12:7];
         pv_ff    <= req_tdata[36:13];
         db_ff    <= req_tdata[54:37];
         ok_ff    <= (req_tdata[3:0] == fblm_pkg::ACT_SEQ_TEST);
         found_ff <= 1'b0;
         fb_ff    <= '0;
         ps_ff    <= fblm_pkg::PG_FREE;
         pd_ff    <= '0;
         free_ff  <= 1'b1;
         full_ff  <= 1'b1;
         fv_ff    <= 1'b0;
      end else if (ev_valid_ff) begin
         unique case (ev_mode_ff)
            fblm_pkg::MODE_PAGE: begin
               if (act_ff == fblm_pkg::ACT_READ) begin
                  ps_ff <= ev_st;
                  pd_ff <= (ev_st == fblm_pkg::PG_VALID) ? ev_sec : '0;
               end
               if (ev_we) begin
                  ok_ff <= 1'b1;
               end
            end
            fblm_pkg::MODE_SCAN: begin
               unique case (act_ff)
                  fblm_pkg::ACT_APPEND_BLK, fblm_pkg::ACT_APPEND_ANY: begin
                     if (ev_st == fblm_pkg::PG_FREE) begin
                        ok_ff <= 1'b1;
                     end
                  end
                  fblm_pkg::ACT_BLK_STATUS, fblm_pkg::ACT_STORE_STATUS: begin
                     if (ev_st != fblm_pkg::PG_FREE) begin
                        free_ff <= 1'b0;
                     end else begin
                        full_ff <= 1'b0;
                     end
                     if ((act_ff == fblm_pkg::ACT_BLK_STATUS) &&
                         (ev_st == fblm_pkg::PG_VALID) && !fv_ff) begin
                        fv_ff <= 1'b1;
                        ps_ff <= fblm_pkg::PG_VALID;
                        pd_ff <= ev_sec;
                     end
                  end
                  fblm_pkg::ACT_FIND_DATA: begin
                     blk_fv_ff <= cur_fv | (ev_st == fblm_pkg::PG_VALID);
                     if ((ev_st == fblm_pkg::PG_VALID) && !cur_fv && !found_ff &&
                         (ev_sec[fblm_pkg::SECT_W-1:fblm_pkg::PAGE_W] == db_ff)) begin
                        found_ff <= 1'b1;
                        fb_ff    <= ev_addr_ff[fblm_pkg::ADDR_W-1:fblm_pkg::PAGE_W];
                        ps_ff    <= fblm_pkg::PG_VALID;
                        pd_ff    <= ev_sec;
                     end
                  end
                  fblm_pkg::ACT_FIND_FREE: begin
                     blk_free_ff <= cur_blk_free;
                     if (pg_last && cur_blk_free && !found_ff) begin
                        found_ff <= 1'b1;
                        fb_ff    <= ev_addr_ff[fblm_pkg::ADDR_W-1:fblm_pkg::PAGE_W];
                     end
                  end
                  fblm_pkg::ACT_SEQ_TEST: begin
                     // page i must hold the block base sector plus i
                     if (pg_first) begin
                        base_ff <= ev_sec[fblm_pkg::SECT_W-1:fblm_pkg::PAGE_W];
                     end
                     if (!((ev_st == fblm_pkg::PG_VALID) &&
                           (ev_sec[fblm_pkg::PAGE_W-1:0] == ev_pg) &&
                           (pg_first ||
                            (ev_sec[fblm_pkg::SECT_W-1:fblm_pkg::PAGE_W] == base_ff)))) begin
                        ok_ff <= 1'b0;
                     end
                  end
                  default: ok_ff <= ok_ff;
               endcase
            end
            fblm_pkg::MODE_FM_PAGE: begin
               if (ev_st == fblm_pkg::PG_VALID) begin
                  d_ff   <= ev_sec[fblm_pkg::SECT_W-1:fblm_pkg::PAGE_W];
                  dup_ff <= 1'b0;
               end
            end
            fblm_pkg::MODE_FM_OUT: begin
               if (ev_st == fblm_pkg::PG_VALID) begin
                  v_ff <= ev_sec;
               end
            end
            default: v_ff <= v_ff;
         endcase
      end
      if (seen_v_ff && (seen_q_ff == d_ff)) begin
         dup_ff <= 1'b1;
      end
   end

   // counter and victim updates at the end of an action
   always_comb begin
      erase_inc = '0;
      fm_inc    = '0;
      sw_inc    = 1'b0;
      adv       = 1'b0;
      unique case (act_ff)
         fblm_pkg::ACT_ERASE: erase_inc = 8'd1;
         fblm_pkg::ACT_SWITCH_MERGE: begin
            erase_inc = 8'd1;
            sw_inc    = 1'b1;
         end
         fblm_pkg::ACT_MERGE: begin
            erase_inc = 8'd2;
            fm_inc    = 8'd1;
         end
         fblm_pkg::ACT_FULL_MERGE: begin
            erase_inc = {1'b0, seen_cnt_ff} + 8'd1;
            fm_inc    = {1'b0, seen_cnt_ff};
            adv       = 1'b1;
         end
         fblm_pkg::ACT_ADV_VICTIM: adv = 1'b1;
         default: adv = 1'b0;
      endcase
   end

   assign victim_nxt  = victim_ff + 1'b1;
   assign victim_last = {1'b0, first_ff} + fblm_pkg::VIC_W'(fblm_pkg::BLOCKS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_ff  <= '0;
         switch_ff <= '0;
         fmerge_ff <= '0;
         victim_ff <= '0;
         first_ff  <= '0;
      end else if (csr_wr_en) begin
         first_ff  <= csr_wr_data;
         victim_ff <= {1'b0, csr_wr_data};
      end else if (cmd.fin) begin
         erase_ff  <= sat_add(erase_ff, erase_inc);
         switch_ff <= sat_add(switch_ff, {{fblm_pkg::SEEN_CNT_W{1'b0}}, sw_inc});
         fmerge_ff <= sat_add(fmerge_ff, fm_inc);
         if (adv) begin
            victim_ff <= (victim_nxt <= victim_last) ? victim_nxt : {1'b0, first_ff};
         end
      end
   end

   assign status_act = (act_ff == fblm_pkg::ACT_BLK_STATUS) ||
                       (act_ff == fblm_pkg::ACT_STORE_STATUS);

   always_ff @(posedge clock) begin
      if (cmd.result) begin
         rsp_data_ff <= {6'd0, fmerge_ff, switch_ff, erase_ff, victim_ff,
                         full_ff & status_act, free_ff & status_act,
                         pd_ff, ps_ff, fb_ff, found_ff, ok_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign stat.act        = act_ff;
   assign stat.blk        = blk_ff;
   assign stat.off        = off_ff;
   assign stat.page_valid = ev_valid_ff && (ev_st == fblm_pkg::PG_VALID);
   assign stat.seen_cnt   = seen_cnt_ff;
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_tready;
   assign stat.ev_write   = ev_we;
   assign stat.ev_valid   = ev_valid_ff;

endmodule

// ----- hw/rtl/fblm_ctrl.sv -----
module fblm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  fblm_pkg::stat_type stat,
   output fblm_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_PAGE_E, ST_SCAN, ST_SCAN_E, ST_ERASE,
      ST_FM_PG, ST_FM_PG_E, ST_FM_SEEN, ST_FM_SEEN_E, ST_FM_ADD,
      ST_FM_OUT, ST_FM_OUT_E, ST_FM_INV, ST_FM_INV_E, ST_FINISH, ST_RESP
   } state_type;

   state_type                   state_ff, state_in;
   logic [fblm_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [fblm_pkg::PAGE_W-1:0] pg_ff, pg_in, k_ff, k_in;
   logic                        store_ff, store_in;
   logic [fblm_pkg::PAGE_W-1:0] last_k;
   logic                        scan_last;

   assign last_k    = stat.seen_cnt[fblm_pkg::PAGE_W-1:0] - 1'b1;
   assign scan_last = store_ff ? (addr_ff == fblm_pkg::ADDR_W'(fblm_pkg::STORE_LAST))
                               : (addr_ff[fblm_pkg::PAGE_W-1:0] == '1);

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      pg_in    = pg_ff;
      k_in     = k_ff;
      store_in = store_ff;
      cmd      = '0;
      cmd.addr = addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_free = 1'b1;
            addr_in     = addr_ff + 1'b1;
            if (addr_ff == fblm_pkg::ADDR_W'(fblm_pkg::STORE_LAST)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.act)
               fblm_pkg::ACT_READ, fblm_pkg::ACT_WRITE: begin
                  cmd.rd_en = 1'b1;
                  cmd.addr  = {stat.blk, stat.off};
                  cmd.mode  = fblm_pkg::MODE_PAGE;
                  state_in  = ST_PAGE_E;
               end
               fblm_pkg::ACT_APPEND_BLK, fblm_pkg::ACT_BLK_STATUS,
               fblm_pkg::ACT_SEQ_TEST: begin
                  addr_in  = {stat.blk, {fblm_pkg::PAGE_W{1'b0}}};
                  store_in = 1'b0;
                  state_in = ST_SCAN;
               end
               fblm_pkg::ACT_APPEND_ANY, fblm_pkg::ACT_STORE_STATUS,
               fblm_pkg::ACT_FIND_DATA, fblm_pkg::ACT_FIND_FREE: begin
                  addr_in  = '0;
                  store_in = 1'b1;
                  state_in = ST_SCAN;
               end
               fblm_pkg::ACT_ERASE, fblm_pkg::ACT_SWITCH_MERGE, fblm_pkg::ACT_MERGE: begin
                  addr_in  = {stat.blk, {fblm_pkg::PAGE_W{1'b0}}};
                  state_in = ST_ERASE;
               end
               fblm_pkg::ACT_FULL_MERGE: begin
                  pg_in    = '0;
                  state_in = ST_FM_PG;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_PAGE_E: state_in = ST_FINISH;
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            cmd.mode  = fblm_pkg::MODE_SCAN;
            addr_in   = addr_ff + 1'b1;
            if (scan_last) begin
               state_in = ST_SCAN_E;
            end
         end
         ST_SCAN_E: state_in = ST_FINISH;
         ST_ERASE: begin
            cmd.wr_free = 1'b1;
            addr_in     = addr_ff + 1'b1;
            if (addr_ff[fblm_pkg::PAGE_W-1:0] == '1) begin
               state_in = ST_FINISH;
            end
         end
         // full merge, first pass: gather distinct data blocks
         ST_FM_PG: begin
            cmd.rd_en = 1'b1;
            cmd.addr  = {stat.blk, pg_ff};
            cmd.mode  = fblm_pkg::MODE_FM_PAGE;
            state_in  = ST_FM_PG_E;
         end
         ST_FM_PG_E: begin
            if (stat.page_valid) begin
               k_in     = '0;
               state_in = (stat.seen_cnt == '0) ? ST_FM_ADD : ST_FM_SEEN;
            end else begin
               pg_in    = pg_ff + 1'b1;
               state_in = (pg_ff == '1) ? ST_FM_OUT : ST_FM_PG;
            end
         end
         ST_FM_SEEN: begin
            cmd.seen_rd   = 1'b1;
            cmd.seen_addr = k_ff;
            k_in          = k_ff + 1'b1;
            if (k_ff == last_k) begin
               state_in = ST_FM_SEEN_E;
            end
         end
         ST_FM_SEEN_E: state_in = ST_FM_ADD;
         ST_FM_ADD: begin
            cmd.seen_add = 1'b1;
            pg_in        = pg_ff + 1'b1;
            state_in     = (pg_ff == '1) ? ST_FM_OUT : ST_FM_PG;
         end
         // second pass: each valid sector is invalidated across the store
         ST_FM_OUT: begin
            cmd.rd_en = 1'b1;
            cmd.addr  = {stat.blk, pg_ff};
            cmd.mode  = fblm_pkg::MODE_FM_OUT;
            state_in  = ST_FM_OUT_E;
         end
         ST_FM_OUT_E, ST_FM_INV_E: begin
            if ((state_ff == ST_FM_OUT_E) && stat.page_valid) begin
               addr_in  = '0;
               state_in = ST_FM_INV;
            end else if (pg_ff == '1) begin
               addr_in  = {stat.blk, {fblm_pkg::PAGE_W{1'b0}}};
               state_in = ST_ERASE;
            end else begin
               pg_in    = pg_ff + 1'b1;
               state_in = ST_FM_OUT;
            end
         end
         ST_FM_INV: begin
            cmd.rd_en = 1'b1;
            cmd.mode  = fblm_pkg::MODE_INVAL;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == fblm_pkg::ADDR_W'(fblm_pkg::STORE_LAST)) begin
               state_in = ST_FM_INV_E;
            end
         end
         ST_FINISH: begin
            cmd.fin  = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.result = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         pg_ff    <= '0;
         k_ff     <= '0;
         store_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         pg_ff    <= pg_in;
         k_ff     <= k_in;
         store_ff <= store_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

// ----- hw/rtl/flash_log_block_manager.sv -----
// Log-block table of a block-associative flash translation layer: 8 blocks
// of 64 pages in a page memory with one read and one write port, one action
// per request beat and one response beat per request. After reset a clearing
// pass frees the store before the first request is taken. Scans walk the
// page memory one page a cycle, so an action's length is set by the pages it
// visits: read and write touch one page, block-wide actions (append to a block,
// block status, sequential test, erase, switch merge and merge) walk one block,
// store-wide actions (append anywhere, store status, find data, find free)
// the whole store. A full merge walks its block to collect the distinct data
// blocks, then has every valid page invalidate its sector store-wide, then
// erases the block. A new request is taken while the previous response still
// waits on the output register.
module flash_log_block_manager (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // action[3:0], block[6:4], offset[12:7], page_value[36:13], data_block[54:37]
   input  logic [fblm_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // ok[0], found[1], found_block[4:2], page_state[6:5], page_data[30:7],
   // is_free[31], is_full[32], victim[49:33], erase_total[81:50],
   // switch_merge_total[113:82], full_merge_total[145:114]
   output logic [fblm_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [fblm_pkg::FVN_W-1:0]    csr_wr_data
);

   fblm_pkg::cmd_type  cmd;
   fblm_pkg::stat_type stat;

   fblm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fblm_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // erase sweep and evaluate-stage write never share the memory port
   a_wr_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_free && stat.ev_write))
      else $error("page memory write port conflict");

   // no page read is still in flight when a request is taken
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !stat.ev_valid)
      else $error("request taken with a scan in flight");

   // the response register is only loaded once the previous beat has gone
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result |-> !stat.rsp_busy)
      else $error("response overwritten");

   // distinct data block count never exceeds the pages of one block
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      stat.seen_cnt[fblm_pkg::SEEN_CNT_W-1] |-> (stat.seen_cnt[fblm_pkg::PAGE_W-1:0] == '0))
      else $error("seen count overflow");

endmodule

// ----- dv/fblm_checker.sv -----
`timescale 1ns / 100ps

module fblm_checker
   import fblm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [RSP_W-1:0]   rsp_tdata,
   input  logic               csr_wr_en,
   input  logic [FVN_W-1:0]   csr_wr_data,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      bit              ok;
      bit              found;
      bit [BLK_W-1:0]  found_block;
      bit [1:0]        page_state;
      bit [SECT_W-1:0] page_data;
      bit              is_free;
      bit              is_full;
      bit [VIC_W-1:0]  victim;
      bit [CNT_W-1:0]  erase_total;
      bit [CNT_W-1:0]  switch_total;
      bit [CNT_W-1:0]  fmerge_total;
   } outcome_type;

   bit [1:0]        pg_state [BLOCKS][PAGES];
   bit [SECT_W-1:0] pg_sector [BLOCKS][PAGES];
   bit [FVN_W-1:0]  victim_base;
   bit [VIC_W-1:0]  victim_ptr;
   bit [CNT_W-1:0]  erase_cnt, switch_cnt, fmerge_cnt;
   outcome_type     awaited_q [$];

   assign pending = awaited_q.size();

   function automatic bit [CNT_W-1:0] sat_add(bit [CNT_W-1:0] a, int unsigned n);
      longint unsigned s;
      s = longint'(a) + n;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[CNT_W-1:0];
   endfunction

   function automatic void wipe_block(int b);
      for (int i = 0; i < PAGES; i++) begin
         pg_state[b][i]  = PG_FREE;
         pg_sector[b][i] = '0;
      end
      erase_cnt = sat_add(erase_cnt, 1);
   endfunction

   function automatic bit block_free(int b);
      for (int i = 0; i < PAGES; i++)
         if (pg_state[b][i] != PG_FREE) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit block_full(int b);
      for (int i = 0; i < PAGES; i++)
         if (pg_state[b][i] == PG_FREE) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int first_valid_page(int b);
      for (int i = 0; i < PAGES; i++)
         if (pg_state[b][i] == PG_VALID) return i;
      return -1;
   endfunction

   function automatic bit append_page(int b, bit [SECT_W-1:0] v);
      for (int i = 0; i < PAGES; i++)
         if (pg_state[b][i] == PG_FREE) begin
            pg_state[b][i]  = PG_VALID;
            pg_sector[b][i] = v;
            return 1'b1;
         end
      return 1'b0;
   endfunction

   function automatic bit block_sequential(int b);
      bit [SECT_W-1:0] base;
      if (pg_state[b][0] != PG_VALID) return 1'b0;
      base = pg_sector[b][0];
      if (base[PAGE_W-1:0] != 0) return 1'b0;
      for (int i = 1; i < PAGES; i++) begin
         if (pg_state[b][i] != PG_VALID) return 1'b0;
         if (pg_sector[b][i] != base + i) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void step_victim();
      int unsigned last;
      last = int'(victim_base) + BLOCKS - 1;
      if (int'(victim_ptr) + 1 <= last) victim_ptr = VIC_W'(victim_ptr + 1);
      else victim_ptr = {1'b0, victim_base};
   endfunction

   function automatic void merge_block_full(int b);
      bit [DB_W-1:0] seen [$];
      bit [SECT_W-1:0] v;
      bit dup;
      for (int i = 0; i < PAGES; i++) begin
         if (pg_state[b][i] != PG_VALID) continue;
         dup = 1'b0;
         foreach (seen[k]) if (seen[k] == pg_sector[b][i][SECT_W-1:PAGE_W]) dup = 1'b1;
         if (!dup) seen = {seen, pg_sector[b][i][SECT_W-1:PAGE_W]};
      end
      for (int i = 0; i < PAGES; i++) begin
         if (pg_state[b][i] != PG_VALID) continue;
         v = pg_sector[b][i];
         for (int j = 0; j < BLOCKS; j++)
            for (int k = 0; k < PAGES; k++)
               if (pg_state[j][k] == PG_VALID && pg_sector[j][k] == v) begin
                  pg_state[j][k]  = PG_INVALID;
                  pg_sector[j][k] = '0;
               end
      end
      erase_cnt  = sat_add(erase_cnt, seen.size());
      fmerge_cnt = sat_add(fmerge_cnt, seen.size());
      wipe_block(b);
      step_victim();
   endfunction

   function automatic outcome_type apply_action(logic [REQ_W-1:0] d);
      outcome_type     o;
      act_type         a;
      int              b, off, f;
      bit [SECT_W-1:0] pv;
      bit [DB_W-1:0]   db;
      o   = '{default: '0};
      a   = act_type'(d[3:0]);
      b   = int'(d[6:4]);
      off = int'(d[12:7]);
      pv  = d[36:13];
      db  = d[54:37];
      case (a)
         ACT_ERASE: wipe_block(b);
         ACT_READ: begin
            o.page_state = pg_state[b][off];
            if (pg_state[b][off] == PG_VALID) o.page_data = pg_sector[b][off];
         end
         ACT_WRITE: begin
            if (pg_state[b][off] == PG_FREE) begin
               pg_state[b][off]  = PG_VALID;
               pg_sector[b][off] = pv;
               o.ok = 1'b1;
            end
         end
         ACT_APPEND_BLK: o.ok = append_page(b, pv);
         ACT_APPEND_ANY: begin
            for (int i = 0; i < BLOCKS; i++)
               if (!block_full(i)) begin
                  o.ok = append_page(i, pv);
                  break;
               end
         end
         ACT_BLK_STATUS: begin
            o.is_free = block_free(b);
            o.is_full = block_full(b);
            f = first_valid_page(b);
            if (f >= 0) begin
               o.page_state = PG_VALID;
               o.page_data  = pg_sector[b][f];
            end
         end
         ACT_STORE_STATUS: begin
            o.is_free = 1'b1;
            o.is_full = 1'b1;
            for (int i = 0; i < BLOCKS; i++) begin
               if (!block_free(i)) o.is_free = 1'b0;
               if (!block_full(i)) o.is_full = 1'b0;
            end
         end
         ACT_FIND_DATA: begin
            for (int i = 0; i < BLOCKS; i++) begin
               f = first_valid_page(i);
               if (f < 0) continue;
               if (pg_sector[i][f][SECT_W-1:PAGE_W] == db) begin
                  o.found       = 1'b1;
                  o.found_block = BLK_W'(i);
                  o.page_state  = PG_VALID;
                  o.page_data   = pg_sector[i][f];
                  break;
               end
            end
         end
         ACT_FIND_FREE: begin
            for (int i = 0; i < BLOCKS; i++)
               if (block_free(i)) begin
                  o.found       = 1'b1;
                  o.found_block = BLK_W'(i);
                  break;
               end
         end
         ACT_SEQ_TEST: o.ok = block_sequential(b);
         ACT_SWITCH_MERGE: begin
            wipe_block(b);
            switch_cnt = sat_add(switch_cnt, 1);
         end
         ACT_MERGE: begin
            erase_cnt  = sat_add(erase_cnt, 1);
            fmerge_cnt = sat_add(fmerge_cnt, 1);
            wipe_block(b);
         end
         ACT_FULL_MERGE: merge_block_full(b);
         ACT_ADV_VICTIM: step_victim();
         default: ;
      endcase
      o.victim       = victim_ptr;
      o.erase_total  = erase_cnt;
      o.switch_total = switch_cnt;
      o.fmerge_total = fmerge_cnt;
      return o;
   endfunction

   function automatic outcome_type unpack_rsp(logic [RSP_W-1:0] d);
      outcome_type o;
      o.ok           = d[0];
      o.found        = d[1];
      o.found_block  = d[4:2];
      o.page_state   = d[6:5];
      o.page_data    = d[30:7];
      o.is_free      = d[31];
      o.is_full      = d[32];
      o.victim       = d[49:33];
      o.erase_total  = d[81:50];
      o.switch_total = d[113:82];
      o.fmerge_total = d[145:114];
      return o;
   endfunction

   function automatic void report_field(string name, longint unsigned exp_v,
                                        longint unsigned got_v);
      if (exp_v == got_v) return;
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, name, exp_v, got_v);
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      outcome_type e, g;
      if (reset) begin
         foreach (pg_state[i, j]) begin
            pg_state[i][j]  = PG_FREE;
            pg_sector[i][j] = '0;
         end
         victim_base = '0;
         victim_ptr  = '0;
         erase_cnt   = '0;
         switch_cnt  = '0;
         fmerge_cnt  = '0;
         awaited_q.delete();
      end else begin
         if (csr_wr_en) begin
            victim_base = csr_wr_data;
            victim_ptr  = {1'b0, csr_wr_data};
         end
         if (req_tvalid && req_tready) awaited_q = {awaited_q, apply_action(req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            g = unpack_rsp(rsp_tdata);
            if (awaited_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("%0t: response beat with none awaited", $realtime);
            end else begin
               e = awaited_q.pop_front();
               report_field("ok", e.ok, g.ok);
               report_field("found", e.found, g.found);
               report_field("found_block", e.found_block, g.found_block);
               report_field("page_state", e.page_state, g.page_state);
               report_field("page_data", e.page_data, g.page_data);
               report_field("is_free", e.is_free, g.is_free);
               report_field("is_full", e.is_full, g.is_full);
               report_field("victim", e.victim, g.victim);
               report_field("erase_total", e.erase_total, g.erase_total);
               report_field("switch_merge_total", e.switch_total, g.switch_total);
               report_field("full_merge_total", e.fmerge_total, g.fmerge_total);
            end
         end
      end
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import fblm_pkg::*;

   localparam longint CYCLE_LIMIT = 60_000_000;

   logic               clock, reset;
   logic               req_tvalid, req_tready;
   logic [REQ_W-1:0]   req_tdata;
   logic               rsp_tvalid, rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_wr_en;
   logic [FVN_W-1:0]   csr_wr_data;
   int                 fail_count, pending;
   longint             cycles;
   int                 burst_left;
   int                 stall_mode, stall_age;

   flash_log_block_manager dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   fblm_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: always ready, light stalls or heavy stalls, mode changes now and then
   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_age  <= $urandom_range(20, 300);
      end else begin
         stall_age <= stall_age - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   function automatic logic [REQ_W-1:0] pack_req(act_type a, int b, int off,
                                                 logic [SECT_W-1:0] pv, logic [DB_W-1:0] db);
      logic [REQ_W-1:0] d;
      d = '0;
      d[3:0]   = a;
      d[6:4]   = BLK_W'(b);
      d[12:7]  = PAGE_W'(off);
      d[36:13] = pv;
      d[54:37] = db;
      return d;
   endfunction

   function automatic logic [SECT_W-1:0] pick_sector();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return {18'($urandom_range(0, 3)), 6'($urandom_range(0, 63))};
      if (r < 8) return 24'($urandom);
      if (r == 8) return 24'hFF_FFFF;
      return '0;
   endfunction

   function automatic logic [DB_W-1:0] pick_data_block();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return DB_W'($urandom_range(0, 3));
      if (r < 9) return 18'($urandom);
      return 18'h3_FFFF;
   endfunction

   function automatic logic [REQ_W-1:0] random_req();
      int      r;
      act_type a;
      r = $urandom_range(0, 99);
      if (r < 3)       a = ACT_ERASE;
      else if (r < 15) a = ACT_READ;
      else if (r < 30) a = ACT_WRITE;
      else if (r < 50) a = ACT_APPEND_BLK;
      else if (r < 53) a = ACT_APPEND_ANY;
      else if (r < 61) a = ACT_BLK_STATUS;
      else if (r < 64) a = ACT_STORE_STATUS;
      else if (r < 68) a = ACT_FIND_DATA;
      else if (r < 71) a = ACT_FIND_FREE;
      else if (r < 76) a = ACT_SEQ_TEST;
      else if (r < 79) a = ACT_SWITCH_MERGE;
      else if (r < 82) a = ACT_MERGE;
      else if (r < 84) a = ACT_FULL_MERGE;
      else if (r < 90) a = ACT_ADV_VICTIM;
      else             a = ACT_APPEND_BLK;
      return pack_req(a, $urandom_range(0, BLOCKS - 1), $urandom_range(0, PAGES - 1),
                      pick_sector(), pick_data_block());
   endfunction

   // one beat; valid stays high across a burst, drops only for a gap
   task automatic send_beat(logic [REQ_W-1:0] d);
      int gap;
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic send(act_type a, int b, int off, logic [SECT_W-1:0] pv,
                       logic [DB_W-1:0] db);
      send_beat(pack_req(a, b, off, pv, db));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_first_victim(logic [FVN_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // erase a block, append a run of sectors; a broken run skips or bends one; probe it
   task automatic sequential_run(int b);
      logic [SECT_W-1:0] base;
      int                bend;
      base = ($urandom_range(0, 3) == 0) ? {18'($urandom), 6'd0}
                                         : {18'($urandom_range(0, 3)), 6'd0};
      bend = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PAGES - 1) : -1;
      send(ACT_ERASE, b, 0, '0, '0);
      for (int i = 0; i < PAGES; i++)
         send(ACT_APPEND_BLK, b, 0, (i == bend) ? SECT_W'(base + i + 1) : SECT_W'(base + i),
              '0);
      send(ACT_SEQ_TEST, b, 0, '0, '0);
      send(ACT_BLK_STATUS, b, 0, '0, '0);
      send(ACT_FIND_DATA, 0, 0, '0, base[SECT_W-1:PAGE_W]);
      case ($urandom_range(0, 3))
         0: send(ACT_SWITCH_MERGE, b, 0, '0, '0);
         1: send(ACT_FULL_MERGE, b, 0, '0, '0);
         default: ;
      endcase
   endtask

   task automatic random_phase(int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(0, 99) < 2) begin
            sequential_run($urandom_range(0, BLOCKS - 1));
            sent += PAGES + 4;
         end else begin
            send_beat(random_req());
            sent++;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      cycles      = 0;
      burst_left  = 1;
      stall_mode  = 0;
      stall_age   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_first_victim(16'd0);

      send(ACT_STORE_STATUS, 0, 0, '0, '0);
      send(ACT_FIND_FREE, 0, 0, '0, '0);
      send(ACT_WRITE, 7, 63, 24'hFF_FFFF, '0);
      send(ACT_READ, 7, 63, '0, '0);
      send(ACT_READ, 0, 0, '0, '0);
      send(ACT_WRITE, 7, 63, 24'h12_3456, '0);
      send(ACT_APPEND_BLK, 7, 0, 24'h00_0000, '0);
      send(ACT_APPEND_ANY, 0, 0, 24'h00_0041, '0);
      send(ACT_BLK_STATUS, 7, 0, '0, '0);
      send(ACT_BLK_STATUS, 1, 0, '0, '0);
      send(ACT_FIND_DATA, 0, 0, '0, 18'h3_FFFF);
      send(ACT_FIND_DATA, 0, 0, '0, 18'h0_0005);
      send(ACT_FIND_FREE, 0, 0, '0, '0);
      send(ACT_SEQ_TEST, 7, 0, '0, '0);
      send(ACT_WRITE, 2, 5, 24'hFF_FFFF, '0);
      send(ACT_FULL_MERGE, 7, 0, '0, '0);
      send(ACT_READ, 2, 5, '0, '0);
      send(ACT_SWITCH_MERGE, 0, 0, '0, '0);
      send(ACT_MERGE, 3, 0, '0, '0);
      send(ACT_ERASE, 2, 0, '0, '0);
      for (int i = 0; i < 4; i++) send(ACT_ADV_VICTIM, 0, 0, '0, '0);
      wait_idle();

      // top of the victim range, wraps past 16 bits
      set_first_victim(16'hFFFF);
      for (int i = 0; i < 10; i++) send(ACT_ADV_VICTIM, 0, 0, '0, '0);
      random_phase(430);
      wait_idle();

      // fill the whole store, then probe the full cases
      set_first_victim(16'hFFF8);
      for (int b = 0; b < BLOCKS; b++) send(ACT_ERASE, b, 0, '0, '0);
      for (int b = 0; b < BLOCKS; b++)
         for (int i = 0; i < PAGES; i++) send(ACT_APPEND_BLK, b, 0, pick_sector(), '0);
      send(ACT_STORE_STATUS, 0, 0, '0, '0);
      send(ACT_APPEND_ANY, 0, 0, 24'h00_1234, '0);
      send(ACT_APPEND_BLK, 4, 0, 24'h00_1234, '0);
      send(ACT_FIND_FREE, 0, 0, '0, '0);
      send(ACT_BLK_STATUS, 4, 0, '0, '0);
      send(ACT_FULL_MERGE, 0, 0, '0, '0);
      send(ACT_STORE_STATUS, 0, 0, '0, '0);
      random_phase(180);
      wait_idle();

      set_first_victim(16'($urandom));
      random_phase(430);
      wait_idle();

      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
